// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the speed ramp RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SRB_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Invariant checked on every rising clock edge outside reset.
`define SRB_ALWAYS(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ----- rtl/srb_pkg.sv -----
// Package with the types and constants of the speed ramp with braking block.
package srb_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned StepW    = 31;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned RootW    = 32;
  localparam int unsigned RemW     = 35;
  localparam int unsigned IterCnt  = 32;
  localparam int unsigned IterW    = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned InUserW  = 2;

  localparam logic [StepW-1:0]   ACCEL_RESET = 31'd65536;
  localparam logic [StepW-1:0]   DECEL_RESET = 31'd65536;
  localparam logic [CfgIdxW-1:0] REG_ACCEL   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DECEL   = 2'd1;
  localparam logic [IterW-1:0]   ITER_LAST   = 5'(IterCnt - 1);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SYNC  = 9'b000000010,
    ST_STEP  = 9'b000000100,
    ST_CLAMP = 9'b000001000,
    ST_MUL   = 9'b000010000,
    ST_GO    = 9'b000100000,
    ST_ROOT  = 9'b001000000,
    ST_CAP   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;

endpackage

// ----- rtl/speed_ramp_with_braking_top.sv -----
// Top level of the speed ramp with braking: sequencer, ramp arithmetic and ports.
//
//   channel   direction  beat contents
//   in_       slave      tuser: reset_request, distance_valid; tdata: goal, measured, distance
//   out_      master     tdata: ramped_speed
//   cfg_      slave      cfg_index, cfg_data; always ready
//
// An item runs sync, step, clamp and, with braking, mul, go, root and cap states, then out.
// A reset request goes from idle straight to out. in_tready is high only while the sequencer is idle.
// The next item is accepted while a result still waits in the output register.
// Reset (synchronous, active low) clears the ramp and loads both step registers with 1.0.
`include "assert_macros.svh"

module speed_ramp_with_braking_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [31:0] goal_speed, [63:32] measured_speed, [95:64] remaining_distance
  input  logic [srb_pkg::InDataW-1:0]   in_tdata,
  // [0] reset_request, [1] distance_valid
  input  logic [srb_pkg::InUserW-1:0]   in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] ramped_speed
  output logic [srb_pkg::DataW-1:0]     out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [srb_pkg::DataW-1:0]     cfg_data
);

  srb_pkg::state_t state_r, state_nxt;

  logic        [srb_pkg::StepW-1:0] accel_r, decel_r;
  logic signed [srb_pkg::DataW-1:0] ramp_value_r, ramp_value_nxt;
  logic signed [srb_pkg::DataW-1:0] r_r, r_nxt;
  logic signed [srb_pkg::DataW-1:0] goal_r, goal_nxt;
  logic signed [srb_pkg::DataW-1:0] meas_r, meas_nxt;
  logic        [srb_pkg::DataW-1:0] absd_r, absd_nxt;
  logic                             dvalid_r, dvalid_nxt;
  logic        [srb_pkg::ProdW-1:0] prod_r, prod_nxt;
  logic                             out_tvalid_r, out_tvalid_nxt;
  logic        [srb_pkg::DataW-1:0] out_tdata_r, out_tdata_nxt;

  srb_pkg::sqrt_req_t sqrt_req;
  srb_pkg::sqrt_rsp_t sqrt_rsp;

  logic signed [srb_pkg::DataW-1:0] in_goal, in_meas, in_dist;
  logic signed [srb_pkg::DataW:0]   dist_ext, dist_abs;
  logic signed [srb_pkg::DataW:0]   d_mr, d_gr, d_gm;
  logic signed [srb_pkg::DataW+1:0] sum;
  logic        [srb_pkg::StepW-1:0] step;
  logic signed [srb_pkg::DataW:0]   r_abs;
  logic                             out_free;

  assign in_goal = in_tdata[31:0];
  assign in_meas = in_tdata[63:32];
  assign in_dist = in_tdata[95:64];

  assign dist_ext = {in_dist[srb_pkg::DataW-1], in_dist};
  assign dist_abs = dist_ext[srb_pkg::DataW] ? -dist_ext : dist_ext;

  assign d_mr = {meas_r[srb_pkg::DataW-1], meas_r} - {r_r[srb_pkg::DataW-1], r_r};
  assign d_gr = {goal_r[srb_pkg::DataW-1], goal_r} - {r_r[srb_pkg::DataW-1], r_r};
  assign d_gm = {goal_r[srb_pkg::DataW-1], goal_r} - {meas_r[srb_pkg::DataW-1], meas_r};

  assign step = ((meas_r > 0 && d_gm < 0) || (meas_r < 0 && d_gm > 0)) ? decel_r : accel_r;
  assign sum  = (d_gm >= 0) ? ({{2{r_r[srb_pkg::DataW-1]}}, r_r} + {3'b000, step})
                            : ({{2{r_r[srb_pkg::DataW-1]}}, r_r} - {3'b000, step});
  assign r_abs = r_r[srb_pkg::DataW-1] ? -{r_r[srb_pkg::DataW-1], r_r}
                                       : {r_r[srb_pkg::DataW-1], r_r};

  assign out_free = !out_tvalid_r || out_tready;

  assign sqrt_req.start    = (state_r == srb_pkg::ST_GO);
  assign sqrt_req.radicand = prod_r;

  srb_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    r_nxt          = r_r;
    goal_nxt       = goal_r;
    meas_nxt       = meas_r;
    absd_nxt       = absd_r;
    dvalid_nxt     = dvalid_r;
    prod_nxt       = prod_r;
    ramp_value_nxt = ramp_value_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      srb_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          goal_nxt   = in_goal;
          meas_nxt   = in_meas;
          absd_nxt   = dist_abs[srb_pkg::DataW-1:0];
          dvalid_nxt = in_tuser[1];
          if (in_tuser[0]) begin
            r_nxt     = '0;
            state_nxt = srb_pkg::ST_OUT;
          end else begin
            r_nxt     = ramp_value_r;
            state_nxt = srb_pkg::ST_SYNC;
          end
        end
      end
      srb_pkg::ST_SYNC: begin
        if ((d_mr > 0 && d_gr > 0) || (d_mr < 0 && d_gr < 0)) begin
          r_nxt = meas_r;
        end
        state_nxt = srb_pkg::ST_STEP;
      end
      srb_pkg::ST_STEP: begin
        if (sum[srb_pkg::DataW+1:srb_pkg::DataW-1] == 3'b000 ||
            sum[srb_pkg::DataW+1:srb_pkg::DataW-1] == 3'b111) begin
          r_nxt = sum[srb_pkg::DataW-1:0];
        end else if (sum[srb_pkg::DataW+1]) begin
          r_nxt = 32'sh8000_0000;
        end else begin
          r_nxt = 32'sh7FFF_FFFF;
        end
        state_nxt = srb_pkg::ST_CLAMP;
      end
      srb_pkg::ST_CLAMP: begin
        if ((d_gm > 0 && d_gr < 0) || (d_gm < 0 && d_gr > 0)) begin
          r_nxt = goal_r;
        end
        state_nxt = dvalid_r ? srb_pkg::ST_MUL : srb_pkg::ST_OUT;
      end
      srb_pkg::ST_MUL: begin
        prod_nxt  = {decel_r, 1'b0} * absd_r;
        state_nxt = srb_pkg::ST_GO;
      end
      srb_pkg::ST_GO: begin
        state_nxt = srb_pkg::ST_ROOT;
      end
      srb_pkg::ST_ROOT: begin
        if (sqrt_rsp.done) begin
          state_nxt = srb_pkg::ST_CAP;
        end
      end
      srb_pkg::ST_CAP: begin
        if ({1'b0, r_abs[srb_pkg::DataW-1:0]} > {1'b0, sqrt_rsp.root}) begin
          r_nxt = r_r[srb_pkg::DataW-1] ? -sqrt_rsp.root : sqrt_rsp.root;
        end
        state_nxt = srb_pkg::ST_OUT;
      end
      srb_pkg::ST_OUT: begin
        if (out_free) begin
          out_tdata_nxt  = r_r;
          out_tvalid_nxt = 1'b1;
          ramp_value_nxt = r_r;
          state_nxt      = srb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= srb_pkg::ST_IDLE;
      ramp_value_r <= '0;
      out_tvalid_r <= 1'b0;
      accel_r      <= srb_pkg::ACCEL_RESET;
      decel_r      <= srb_pkg::DECEL_RESET;
    end else begin
      state_r      <= state_nxt;
      ramp_value_r <= ramp_value_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_index == srb_pkg::REG_ACCEL) begin
        accel_r <= cfg_data[srb_pkg::StepW-1:0];
      end
      if (cfg_valid && cfg_index == srb_pkg::REG_DECEL) begin
        decel_r <= cfg_data[srb_pkg::StepW-1:0];
      end
    end
    r_r         <= r_nxt;
    goal_r      <= goal_nxt;
    meas_r      <= meas_nxt;
    absd_r      <= absd_nxt;
    dvalid_r    <= dvalid_nxt;
    prod_r      <= prod_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == srb_pkg::ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

  `SRB_ASSERT(a_one_item, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "item overlap")
  `SRB_ALWAYS(a_start_idle, clk, rst_n, !(sqrt_req.start && sqrt_rsp.busy), "sqrt restarted")
  `SRB_ALWAYS(a_out_ramp, clk, rst_n, !out_tvalid_r || out_tdata_r == ramp_value_r,
              "result differs from ramp state")

endmodule

// ----- rtl/srb_sqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
`include "assert_macros.svh"

module srb_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  srb_pkg::sqrt_req_t req,
  output srb_pkg::sqrt_rsp_t rsp
);

  logic [srb_pkg::ProdW-1:0] n_r, n_nxt;
  logic [srb_pkg::RemW-1:0]  rem_r, rem_nxt;
  logic [srb_pkg::RootW-1:0] root_r, root_nxt;
  logic [srb_pkg::IterW-1:0] cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;

  logic [srb_pkg::RemW-1:0]  rem_sh;
  logic [srb_pkg::RemW-1:0]  trial;

  assign rem_sh = {rem_r[srb_pkg::RemW-3:0], n_r[srb_pkg::ProdW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      n_nxt    = req.radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[srb_pkg::ProdW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[srb_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[srb_pkg::RootW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == srb_pkg::ITER_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.root = root_r;

  `SRB_ALWAYS(a_done_not_busy, clk, rst_n, !(done_r && busy_r), "sqrt done while busy")
  `SRB_ASSERT(a_start_busy, clk, rst_n, (req.start && !busy_r) |=> busy_r, "sqrt did not start")
  `SRB_ASSERT(a_fell_done, clk, rst_n, $fell(busy_r) |-> done_r, "sqrt stopped without done")

endmodule

// ----- test/tb_speed_ramp_with_braking_top.sv -----
// Self-checking testbench for the speed ramp with braking: random stream traffic against a predictor.
module tb_speed_ramp_with_braking_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srb_pkg::*;

  localparam int ONE = 65536;
  localparam logic signed [31:0] SPD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SPD_MIN = 32'sh8000_0000;
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 45;

  typedef struct {
    logic              rst_req;
    logic              dist_ok;
    logic signed [31:0] goal;
    logic signed [31:0] meas;
    logic signed [31:0] remain;
  } tick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic [InUserW-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DataW-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [DataW-1:0] cfg_data = '0;

  tick_t pending_ticks[$];
  logic [31:0] setpoints_due[$];
  tick_t on_bus;

  logic [StepW-1:0] accel_now = ACCEL_RESET;
  logic [StepW-1:0] decel_now = DECEL_RESET;
  logic signed [31:0] ramp_now = '0;

  logic steady = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned gap_left = 0;
  int unsigned quiet = 0;
  int unsigned fails = 0;
  int unsigned n_ticks = 0;
  int unsigned n_resets = 0;
  int unsigned n_braked = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 0;

  speed_ramp_with_braking_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int sgn(longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  function automatic longint clip32(longint v);
    if (v > longint'(SPD_MAX)) return longint'(SPD_MAX);
    if (v < longint'(SPD_MIN)) return longint'(SPD_MIN);
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Advances the ramp setpoint by one control tick and returns the new setpoint.
  function automatic logic [31:0] next_setpoint(tick_t t);
    longint g, m, r, d, dir, step;
    longint unsigned absd, brake, absr;
    if (t.rst_req) begin
      ramp_now = '0;
      return '0;
    end
    g = t.goal;
    m = t.meas;
    r = ramp_now;
    if (sgn(m - r) * sgn(g - r) > 0) r = m;
    dir = g - m;
    if (sgn(m) * sgn(dir) >= 0) step = longint'(accel_now);
    else step = longint'(decel_now);
    r = clip32(dir >= 0 ? r + step : r - step);
    if (sgn(g - m) * sgn(g - r) < 0) r = g;
    if (t.dist_ok) begin
      d = t.remain;
      absd = longint'(d < 0 ? -d : d);
      brake = floor_root(64'd2 * longint'(decel_now) * absd);
      absr = longint'(r < 0 ? -r : r);
      if (absr > brake) r = (r >= 0) ? longint'(brake) : -longint'(brake);
    end
    ramp_now = 32'(clip32(r));
    return ramp_now;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (steady) return 0;
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] any_speed();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 4))
          0: return SPD_MIN;
          1: return SPD_MAX;
          2: return 32'd0;
          3: return 32'hffff_ffff;
          default: return 32'd1;
        endcase
      end
      default: return 32'($urandom_range(0, 100 * ONE)) - 32'(50 * ONE);
    endcase
  endfunction

  // Sender: offers pending beats and predicts each accepted one.
  always @(posedge clk) begin : sender
    tick_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        n_ticks++;
        if (on_bus.rst_req) n_resets++;
        else if (on_bus.dist_ok) n_braked++;
        setpoints_due.push_back(next_setpoint(on_bus));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          nxt = pending_ticks.pop_front();
          on_bus = nxt;
          in_tdata <= {nxt.remain, nxt.meas, nxt.goal};
          in_tuser <= {nxt.dist_ok, nxt.rst_req};
          in_tvalid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off, and the result check.
  always @(posedge clk) begin : receiver
    logic [31:0] due;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (setpoints_due.size() == 0) begin
          $error("ramped_speed: unexpected beat, actual %0d", $signed(out_tdata));
          fails++;
        end else begin
          due = setpoints_due.pop_front();
          n_checked++;
          if (out_tdata !== due) begin
            $error("ramped_speed: expected %0d, actual %0d", $signed(due), $signed(out_tdata));
            fails++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ACCEL) accel_now = val[StepW-1:0];
    else if (idx == REG_DECEL) decel_now = val[StepW-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_steps(input logic [31:0] accel, input logic [31:0] decel);
    write_reg(REG_ACCEL, accel);
    write_reg(REG_DECEL, decel);
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
    n_settings++;
  endtask

  task automatic add(input logic rq, input logic dok, input logic [31:0] g,
                     input logic [31:0] m, input logic [31:0] d);
    tick_t t;
    t.rst_req = rq;
    t.dist_ok = dok;
    t.goal = g;
    t.meas = m;
    t.remain = d;
    pending_ticks.push_back(t);
  endtask

  // Runs of ticks that chase one goal with a converging speed and a shrinking distance,
  // mixed with unrelated noise ticks.
  task automatic queue_runs(input int unsigned total);
    int unsigned made;
    int unsigned len;
    logic [31:0] g, m, d;
    made = 0;
    while (made < total) begin
      len = $urandom_range(4, 24);
      g = any_speed();
      m = any_speed();
      d = any_speed();
      repeat (len) begin
        if ($urandom_range(0, 4) == 0) begin
          add($urandom_range(0, 9) == 0, 1'($urandom()), $urandom(), $urandom(), $urandom());
        end else begin
          add($urandom_range(0, 39) == 0, $urandom_range(0, 2) != 0, g, m, d);
          m = 32'(longint'($signed(m)) +
                  ((longint'($signed(g)) - longint'($signed(m))) >>> $urandom_range(1, 3)) +
                  longint'($urandom_range(0, 2 * ONE)) - longint'(ONE));
          d = 32'(longint'($signed(d)) * 3 / 4);
        end
        made++;
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || setpoints_due.size() != 0 || in_tvalid);
  endtask

  initial begin : stimulus
    logic [31:0] accel, decel;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add(1'b1, 1'b1, $urandom(), $urandom(), $urandom());
    add(1'b0, 1'b0, 0, 0, 0);
    add(1'b0, 1'b0, 5 * ONE, 5 * ONE, 0);
    add(1'b0, 1'b0, SPD_MAX, 0, 0);
    add(1'b0, 1'b0, SPD_MIN, 0, 0);
    add(1'b0, 1'b0, SPD_MIN, SPD_MAX, 0);
    add(1'b0, 1'b0, SPD_MAX, SPD_MIN, 0);
    add(1'b0, 1'b0, 10 * ONE, 5 * ONE, 0);
    add(1'b0, 1'b0, ONE / 2, 0, 0);
    add(1'b0, 1'b0, -10 * ONE, -2 * ONE, 0);
    add(1'b0, 1'b0, SPD_MAX, SPD_MAX - 1, 0);
    add(1'b0, 1'b0, SPD_MIN, SPD_MIN + 1, 0);
    add(1'b0, 1'b1, 20 * ONE, 10 * ONE, 0);
    add(1'b0, 1'b1, SPD_MAX, SPD_MAX - 1, SPD_MIN);
    add(1'b0, 1'b1, SPD_MAX, 3 * ONE, SPD_MAX);
    add(1'b0, 1'b1, -30 * ONE, -25 * ONE, ONE / 4);
    add(1'b0, 1'b0, 30 * ONE, 20 * ONE, 3 * ONE);
    add(1'b1, 1'b0, SPD_MAX, SPD_MIN, SPD_MAX);
    add(1'b0, 1'b1, 0, 0, SPD_MIN);
    add(1'b0, 1'b1, -1, 1, -1);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin accel = 0; decel = 0; end
        1: begin accel = 32'hffff_ffff; decel = 32'hffff_ffff; end
        2: begin accel = 32'h7fff_ffff; decel = 0; end
        3: begin accel = 0; decel = 32'h7fff_ffff; end
        4: begin accel = 3277; decel = 13107; end
        5: begin accel = $urandom(); decel = $urandom(); end
        default: begin
          accel = $urandom_range(0, 8 * ONE);
          decel = $urandom_range(0, 8 * ONE);
        end
      endcase
      apply_steps(accel, decel);
      @(negedge clk);
      steady = (ph == 4);
      if (ph == 1) hold_req = 1'b1;
      queue_runs(155);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d ticks (%0d reset requests, %0d with braking) over %0d step settings.",
             n_ticks, n_resets, n_braked, n_settings);
    $display("Checked %0d setpoint beats.", n_checked);
    if (setpoints_due.size() != 0) begin
      $error("ramped_speed: %0d expected beats never arrived", setpoints_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
